[src/ppi_pkg.sv]
// Shared types, constants and arithmetic helpers for the particle pool integrator.
// No dependencies.
package ppi_pkg;

  localparam int unsigned PoolSizeDefault = 64;
  localparam int unsigned CountW          = 7;
  localparam int unsigned CfgIdxW         = 2;
  localparam logic [30:0] LifeReset       = 31'd13107;

  localparam logic [1:0] OpSpawn  = 2'd0;
  localparam logic [1:0] OpTick   = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StDead = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgLifetime = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPullX    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPullY    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPullZ    = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [15:0]        step_delta;
    logic [5:0]         slot_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         live_count;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_prev_x;
    logic signed [31:0] out_prev_y;
    logic signed [31:0] out_prev_z;
  } out_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] prev;
    logic [31:0]      life;
  } ent_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) + $signed({b[31], b});
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return s[31:0];
  endfunction

  // product of Q16.16 and Q0.16, rounded half up back to Q16.16
  function automatic logic [31:0] rnd_q(input logic [48:0] p);
    logic signed [49:0] r;
    r = $signed({p[48], p}) + 50'sd32768;
    return r[47:16];
  endfunction

endpackage

[src/ppi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/particle_pool_integrator_top.sv]
// Particle pool integrator: spawn, Euler tick with compaction, slot read.
// Depends on ppi_pkg and ppi_ram.
//
//   channel | direction | handshake          | payload
//   in      | in        | in_valid/in_stall  | ppi_pkg::in_t
//   out     | out       | out_valid/out_stall| ppi_pkg::out_t
//   cfg     | in        | cfg_valid/ready    | index, 32-bit data
//
// Spawn and unknown opcodes answer directly from idle; read waits for the registered RAM data.
// Tick: scales the pull by the step, then walks the particles over the single particle RAM
// (read, update velocity and lifetime, multiply, write back; expired ones are only marked), then
// compacts by moving the last particle into each marked slot or dropping a marked last slot.
// Reset clears the live count, cull marks, state and config registers; datapath registers and the RAM are not cleared.
// A new item is taken only when the previous result has been transferred.
module particle_pool_integrator_top #(
  parameter int unsigned PoolSize = ppi_pkg::PoolSizeDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ppi_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ppi_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ppi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);

  localparam int unsigned AW = (PoolSize > 1) ? $clog2(PoolSize) : 1;
  localparam int unsigned EW = $bits(ppi_pkg::ent_t);
  localparam logic [ppi_pkg::CountW-1:0] PoolCnt = ppi_pkg::CountW'(PoolSize);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_RDW   = 10'b00_0000_0010,
    S_PRE   = 10'b00_0000_0100,
    S_T_RD  = 10'b00_0000_1000,
    S_T_DAT = 10'b00_0001_0000,
    S_T_MUL = 10'b00_0010_0000,
    S_T_WR  = 10'b00_0100_0000,
    S_C_CHK = 10'b00_1000_0000,
    S_C_MOV = 10'b01_0000_0000,
    S_SPARE = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [30:0]              life_cfg_q;
  logic [2:0][31:0]         pull_q;
  logic [ppi_pkg::CountW-1:0] live_q, live_d, idx_q, idx_d;
  logic [PoolSize-1:0]      mark_q, mark_d;
  logic [15:0]              dt_q, dt_d;
  logic [2:0][31:0]         pv_q, pv_d, vn_q, vn_d;
  logic [2:0][48:0]         prod_q, prod_d;
  logic [31:0]              lf_q, lf_d;
  logic                     out_valid_q, out_valid_d;
  ppi_pkg::out_t            out_q, out_d;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  ppi_pkg::ent_t    wdata, rdata;
  logic [EW-1:0]    rdata_raw;
  logic             in_acc;
  logic [ppi_pkg::CountW-1:0] last;

  ppi_ram #(.Width(EW), .Depth(PoolSize), .AddrW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );
  assign rdata = ppi_pkg::ent_t'(rdata_raw);

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign last        = live_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    live_d      = live_q;
    idx_d       = idx_q;
    mark_d      = mark_q;
    dt_d        = dt_q;
    pv_d        = pv_q;
    vn_d        = vn_q;
    prod_d      = prod_q;
    lf_d        = lf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = idx_q[AW-1:0];
    raddr       = idx_q[AW-1:0];
    wdata       = rdata;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_d            = '0;
          out_d.live_count = live_q;
          unique case (in_data_i.opcode)
            ppi_pkg::OpSpawn: begin
              if (live_q >= PoolCnt) begin
                out_d.status = ppi_pkg::StFull;
              end else begin
                we           = 1'b1;
                waddr        = live_q[AW-1:0];
                wdata.pos    = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
                wdata.prev   = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
                wdata.vel    = {in_data_i.vel_z, in_data_i.vel_y, in_data_i.vel_x};
                wdata.life   = {1'b0, life_cfg_q};
                mark_d[live_q[AW-1:0]] = 1'b0;
                live_d       = live_q + 1'b1;
                out_d.live_count = live_q + 1'b1;
              end
              out_valid_d = 1'b1;
            end
            ppi_pkg::OpTick: begin
              dt_d    = in_data_i.step_delta;
              idx_d   = '0;
              state_d = S_PRE;
            end
            ppi_pkg::OpRead: begin
              if ({1'b0, in_data_i.slot_index} >= live_q) begin
                out_d.status = ppi_pkg::StDead;
                out_valid_d  = 1'b1;
              end else begin
                re      = 1'b1;
                raddr   = in_data_i.slot_index[AW-1:0];
                state_d = S_RDW;
              end
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      S_RDW: begin
        out_d.out_pos_x  = rdata.pos[0];
        out_d.out_pos_y  = rdata.pos[1];
        out_d.out_pos_z  = rdata.pos[2];
        out_d.out_prev_x = rdata.prev[0];
        out_d.out_prev_y = rdata.prev[1];
        out_d.out_prev_z = rdata.prev[2];
        out_valid_d      = 1'b1;
        state_d          = S_IDLE;
      end
      S_PRE: begin
        for (int a = 0; a < 3; a++) begin
          pv_d[a] = ppi_pkg::rnd_q(49'($signed(pull_q[a]) * $signed({1'b0, dt_q})));
        end
        state_d = S_T_RD;
      end
      S_T_RD: begin
        if (idx_q >= live_q) begin
          idx_d   = '0;
          state_d = S_C_CHK;
        end else begin
          re      = 1'b1;
          state_d = S_T_DAT;
        end
      end
      S_T_DAT: begin
        if ($signed(rdata.life) <= 0) begin
          mark_d[idx_q[AW-1:0]] = 1'b1;
          idx_d   = idx_q + 1'b1;
          state_d = S_T_RD;
        end else begin
          for (int a = 0; a < 3; a++) begin
            vn_d[a] = ppi_pkg::sat_add(rdata.vel[a], pv_q[a]);
          end
          lf_d    = ppi_pkg::sat_add(rdata.life, -{16'd0, dt_q});
          state_d = S_T_MUL;
        end
      end
      S_T_MUL: begin
        for (int a = 0; a < 3; a++) begin
          prod_d[a] = 49'($signed(vn_q[a]) * $signed({1'b0, dt_q}));
        end
        state_d = S_T_WR;
      end
      S_T_WR: begin
        we         = 1'b1;
        wdata.prev = rdata.pos;
        wdata.vel  = vn_q;
        wdata.life = lf_q;
        for (int a = 0; a < 3; a++) begin
          wdata.pos[a] = ppi_pkg::sat_add(rdata.pos[a], ppi_pkg::rnd_q(prod_q[a]));
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_T_RD;
      end
      S_C_CHK: begin
        if (idx_q >= live_q) begin
          out_d            = '0;
          out_d.live_count = live_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end else if (!mark_q[idx_q[AW-1:0]]) begin
          idx_d = idx_q + 1'b1;
        end else begin
          mark_d[idx_q[AW-1:0]] = 1'b0;
          if (idx_q != last) begin
            re      = 1'b1;
            raddr   = last[AW-1:0];
            state_d = S_C_MOV;
          end else begin
            live_d = live_q - 1'b1;
          end
        end
      end
      S_C_MOV: begin
        we                     = 1'b1;
        wdata                  = rdata;
        mark_d[idx_q[AW-1:0]]  = mark_q[last[AW-1:0]];
        mark_d[last[AW-1:0]]   = 1'b0;
        live_d                 = live_q - 1'b1;
        state_d                = S_C_CHK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= '0;
      idx_q       <= '0;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
      life_cfg_q  <= ppi_pkg::LifeReset;
      pull_q      <= '0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      idx_q       <= idx_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ppi_pkg::CfgLifetime: life_cfg_q <= cfg_data_i[30:0];
          ppi_pkg::CfgPullX:    pull_q[0]  <= cfg_data_i;
          ppi_pkg::CfgPullY:    pull_q[1]  <= cfg_data_i;
          ppi_pkg::CfgPullZ:    pull_q[2]  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q   <= dt_d;
    pv_q   <= pv_d;
    vn_q   <= vn_d;
    prod_q <= prod_d;
    lf_q   <= lf_d;
    out_q  <= out_d;
  end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for particle_pool_integrator_top: spawn, tick, read and unknown-opcode
// traffic, with a scoreboard class that predicts every result. Depends on ppi_pkg and particle_pool_integrator_top.
module testbench;

  localparam int unsigned PoolSlots = 64;
  localparam longint CycleLimit = 4000000;

  class pool_scoreboard;
    int          pos_mem[PoolSlots][3];
    int          vel_mem[PoolSlots][3];
    int          prev_mem[PoolSlots][3];
    int          life_mem[PoolSlots];
    bit          cull[PoolSlots];
    int unsigned live;
    logic [30:0] life_cfg;
    int          pull[3];
    ppi_pkg::out_t expected_results[$];
    int          errors;

    function new();
      live = 0;
      life_cfg = ppi_pkg::LifeReset;
      pull = '{0, 0, 0};
      errors = 0;
      foreach (cull[i]) cull[i] = 0;
    endfunction

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
    endfunction

    function int scale_by_step(int a, int unsigned d);
      longint p;
      p = longint'(a) * longint'(d) + 64'sd32768;
      return int'(p >>> 16);
    endfunction

    function void write_reg(logic [ppi_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        ppi_pkg::CfgLifetime: life_cfg = data[30:0];
        ppi_pkg::CfgPullX:    pull[0] = data;
        ppi_pkg::CfgPullY:    pull[1] = data;
        ppi_pkg::CfgPullZ:    pull[2] = data;
        default: ;
      endcase
    endfunction

    function void advance(int unsigned d);
      int unsigned i;
      int v;
      for (i = 0; i < live; i++) begin
        if (life_mem[i] <= 0) begin
          cull[i] = 1;
          continue;
        end
        life_mem[i] = sat(longint'(life_mem[i]) - longint'(d));
        for (int a = 0; a < 3; a++) begin
          prev_mem[i][a] = pos_mem[i][a];
          v = sat(longint'(vel_mem[i][a]) + longint'(scale_by_step(pull[a], d)));
          vel_mem[i][a] = v;
          pos_mem[i][a] = sat(longint'(pos_mem[i][a]) + longint'(scale_by_step(v, d)));
        end
      end
      i = 0;
      while (i < live) begin
        if (!cull[i]) begin
          i++;
          continue;
        end
        cull[i] = 0;
        if (i != live - 1) begin
          pos_mem[i] = pos_mem[live-1];
          vel_mem[i] = vel_mem[live-1];
          prev_mem[i] = prev_mem[live-1];
          life_mem[i] = life_mem[live-1];
          cull[i] = cull[live-1];
          cull[live-1] = 0;
        end
        live--;
      end
    endfunction

    function void note_item(ppi_pkg::in_t x);
      ppi_pkg::out_t r;
      r = '0;
      r.status = ppi_pkg::StDone;
      case (x.opcode)
        ppi_pkg::OpSpawn: begin
          if (live >= PoolSlots) begin
            r.status = ppi_pkg::StFull;
          end else begin
            pos_mem[live] = '{x.pos_x, x.pos_y, x.pos_z};
            prev_mem[live] = '{x.pos_x, x.pos_y, x.pos_z};
            vel_mem[live] = '{x.vel_x, x.vel_y, x.vel_z};
            life_mem[live] = int'({1'b0, life_cfg});
            cull[live] = 0;
            live++;
          end
        end
        ppi_pkg::OpTick: advance(32'(x.step_delta));
        ppi_pkg::OpRead: begin
          if (x.slot_index >= live) begin
            r.status = ppi_pkg::StDead;
          end else begin
            r.out_pos_x = pos_mem[x.slot_index][0];
            r.out_pos_y = pos_mem[x.slot_index][1];
            r.out_pos_z = pos_mem[x.slot_index][2];
            r.out_prev_x = prev_mem[x.slot_index][0];
            r.out_prev_y = prev_mem[x.slot_index][1];
            r.out_prev_z = prev_mem[x.slot_index][2];
          end
        end
        default: ;
      endcase
      r.live_count = live[6:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(ppi_pkg::out_t got);
      ppi_pkg::out_t e;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      e = expected_results.pop_front();
      if (got.status !== e.status || got.live_count !== e.live_count ||
          got.out_pos_x !== e.out_pos_x || got.out_pos_y !== e.out_pos_y ||
          got.out_pos_z !== e.out_pos_z || got.out_prev_x !== e.out_prev_x ||
          got.out_prev_y !== e.out_prev_y || got.out_prev_z !== e.out_prev_z) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  ppi_pkg::in_t  in_data_i;
  ppi_pkg::out_t out_data_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [ppi_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  pool_scoreboard sb = new();
  bit     idle_en = 1;
  bit     hold_go = 0;
  bit     long_hold = 0;
  int     stall_left = 0;
  longint cycles = 0;

  particle_pool_integrator_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= long_hold;
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic ppi_pkg::in_t make_item(logic [1:0] op);
    ppi_pkg::in_t x;
    x.opcode = op;
    x.pos_x = pick_q(); x.pos_y = pick_q(); x.pos_z = pick_q();
    x.vel_x = pick_q(); x.vel_y = pick_q(); x.vel_z = pick_q();
    case ($urandom_range(0, 5))
      0: x.step_delta = 16'd0;
      1: x.step_delta = 16'hffff;
      2: x.step_delta = 16'($urandom_range(0, 4000));
      default: x.step_delta = 16'($urandom());
    endcase
    if ($urandom_range(0, 1) == 0 || sb.live == 0) x.slot_index = 6'($urandom());
    else x.slot_index = 6'($urandom_range(0, sb.live - 1));
    return x;
  endfunction

  task automatic send_item(ppi_pkg::in_t x);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_item(x);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ppi_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.write_reg(idx, data);
  endtask

  task automatic set_regs(logic [30:0] life, logic [31:0] px, logic [31:0] py,
                          logic [31:0] pz);
    write_reg(ppi_pkg::CfgLifetime, {1'($urandom_range(0, 1)), life});
    write_reg(ppi_pkg::CfgPullX, px);
    write_reg(ppi_pkg::CfgPullY, py);
    write_reg(ppi_pkg::CfgPullZ, pz);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int n, int spawn_weight);
    int w;
    for (int k = 0; k < n; k++) begin
      w = $urandom_range(0, 99);
      if (w < spawn_weight) send_item(make_item(ppi_pkg::OpSpawn));
      else if (w < spawn_weight + 25) send_item(make_item(ppi_pkg::OpTick));
      else if (w < 95) send_item(make_item(ppi_pkg::OpRead));
      else send_item(make_item(ppi_pkg::OpUnused));
    end
  endtask

  initial begin
    ppi_pkg::in_t x;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = ppi_pkg::CfgLifetime;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pool, extremes, zero and full steps, unknown opcode
    x = make_item(ppi_pkg::OpRead); x.slot_index = 6'd0; send_item(x);
    send_item(make_item(ppi_pkg::OpUnused));
    x = make_item(ppi_pkg::OpTick); x.step_delta = 16'hffff; send_item(x);
    x = make_item(ppi_pkg::OpSpawn);
    x.pos_x = 32'h7fff_ffff; x.pos_y = 32'h8000_0000; x.pos_z = 32'h7fff_ffff;
    x.vel_x = 32'h7fff_ffff; x.vel_y = 32'h8000_0000; x.vel_z = 32'h0;
    send_item(x);
    x.pos_x = 32'h8000_0000; x.pos_y = 32'h7fff_ffff; x.pos_z = 32'h0;
    x.vel_x = 32'h8000_0000; x.vel_y = 32'h7fff_ffff; x.vel_z = 32'hffff_ffff;
    send_item(x);
    for (int s = 0; s < 3; s++) begin
      x = make_item(ppi_pkg::OpRead); x.slot_index = 6'(s); send_item(x);
    end
    x = make_item(ppi_pkg::OpTick); x.step_delta = 16'd0; send_item(x);
    x = make_item(ppi_pkg::OpRead); x.slot_index = 6'd1; send_item(x);
    x = make_item(ppi_pkg::OpTick); x.step_delta = 16'd1; send_item(x);
    x = make_item(ppi_pkg::OpRead); x.slot_index = 6'd0; send_item(x);
    x = make_item(ppi_pkg::OpTick); x.step_delta = 16'hffff; send_item(x);
    x = make_item(ppi_pkg::OpRead); x.slot_index = 6'd0; send_item(x);
    x = make_item(ppi_pkg::OpTick); x.step_delta = 16'd0; send_item(x);
    x = make_item(ppi_pkg::OpRead); x.slot_index = 6'h3f; send_item(x);
    run_random(300, 40);
    drain();

    set_regs(31'd0, 32'h7fff_ffff, 32'h8000_0000, $urandom());
    hold_go = 1'b1;
    run_random(300, 45);
    drain();

    set_regs(31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    for (int k = 0; k < 70; k++) send_item(make_item(ppi_pkg::OpSpawn));
    run_random(280, 35);
    drain();

    set_regs(31'($urandom_range(0, 200000)), $urandom(), $urandom(), $urandom());
    run_random(200, 45);
    idle_en = 1'b0;
    run_random(180, 45);
    drain();

    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

[files.f]
src/ppi_pkg.sv
src/ppi_ram.sv
src/particle_pool_integrator_top.sv
tb/sv/testbench.sv
